>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL files; reset masks every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/bld_pkg.sv
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types, constants and the level clamp of the button lamp dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package bld_pkg;

    localparam int LEVEL_W   = 10;
    localparam int STAMP_W   = 32;
    localparam int RATE_W    = 16;
    localparam int CFG_W     = 16;
    localparam int ELAPSED_W = 21;
    localparam int PROD_W    = RATE_W + ELAPSED_W;
    localparam int STEP_W    = 11;
    localparam int SUM_W     = 13;
    localparam int RECIP_W   = 22;
    localparam int RECIP_SH  = 31;
    localparam int QPROD_W   = ELAPSED_W + RECIP_W;

    // Ramp products at or above this give a step that saturates any level.
    localparam logic [PROD_W-1:0]  STEP_SAT_PROD = PROD_W'(2048000);
    // Ramp products below this give a zero step.
    localparam logic [PROD_W-1:0]  STEP_MIN_PROD = PROD_W'(1000);
    // ceil(2^31 / 1000): exact floor division by 1000 for 21-bit dividends.
    localparam logic [RECIP_W-1:0] RECIP_1000    = RECIP_W'(2147484);

    typedef enum logic [2:0] {
        OP_TOGGLE_PRESS = 3'd0,
        OP_UP_POLL      = 3'd1,
        OP_DOWN_POLL    = 3'd2,
        OP_TOGGLE_REL   = 3'd3,
        OP_UP_REL       = 3'd4,
        OP_DOWN_REL     = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        CFG_HIGH_LIMIT = 3'd0,
        CFG_LOW_LIMIT  = 3'd1,
        CFG_FIRST_STEP = 3'd2,
        CFG_HOLD_WAIT  = 3'd3,
        CFG_RAMP_RATE  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] high_limit;
        logic [LEVEL_W-1:0] low_limit;
        logic [LEVEL_W-1:0] first_step;
        logic [CFG_W-1:0]   hold_wait_ms;
        logic [RATE_W-1:0]  ramp_rate;
    } t_cfg;

    // Item as held in the input register, with ramp products precomputed.
    typedef struct packed {
        logic [2:0]         op;
        logic [STAMP_W-1:0] now_ms;
        logic [PROD_W-1:0]  prod_stamp;  // against the stored button stamp
        logic [PROD_W-1:0]  prod_prev;   // against the previous item's time
        logic               prev_back;   // previous item processed right before
    } t_item;

    typedef struct packed {
        logic [STAMP_W-1:0] up_stamp;
        logic [STAMP_W-1:0] down_stamp;
    } t_stamps;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty_value;
        logic               duty_write;
        logic               lamp_is_on;
    } t_result;

    // The high limit is checked before the low limit.
    function automatic logic [LEVEL_W-1:0] clamp_level(
        input logic signed [SUM_W-1:0] v,
        input logic [LEVEL_W-1:0]      hi,
        input logic [LEVEL_W-1:0]      lo
    );
        logic signed [SUM_W-1:0] hi_s;
        logic signed [SUM_W-1:0] lo_s;
        hi_s = $signed({{(SUM_W-LEVEL_W){1'b0}}, hi});
        lo_s = $signed({{(SUM_W-LEVEL_W){1'b0}}, lo});
        if (v > hi_s) begin
            return hi;
        end else if (v < lo_s) begin
            return lo;
        end else begin
            return v[LEVEL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> src/bld_cfg.sv
// ----------------------------------------------------------------------------
// bld_cfg
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_cfg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [bld_pkg::CFG_W-1:0] i_cfg_data,
    output bld_pkg::t_cfg              o_cfg
);

    bld_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_limit   <= bld_pkg::LEVEL_W'(1023);
            r_cfg.low_limit    <= '0;
            r_cfg.first_step   <= bld_pkg::LEVEL_W'(32);
            r_cfg.hold_wait_ms <= bld_pkg::CFG_W'(500);
            r_cfg.ramp_rate    <= bld_pkg::RATE_W'(200);
        end else if (i_cfg_valid) begin
            unique case (bld_pkg::t_cfg_idx'(i_cfg_index))
                bld_pkg::CFG_HIGH_LIMIT: r_cfg.high_limit <= i_cfg_data[bld_pkg::LEVEL_W-1:0];
                bld_pkg::CFG_LOW_LIMIT:  r_cfg.low_limit  <= i_cfg_data[bld_pkg::LEVEL_W-1:0];
                bld_pkg::CFG_FIRST_STEP: r_cfg.first_step <= i_cfg_data[bld_pkg::LEVEL_W-1:0];
                bld_pkg::CFG_HOLD_WAIT:  r_cfg.hold_wait_ms <= i_cfg_data;
                bld_pkg::CFG_RAMP_RATE:  r_cfg.ramp_rate  <= i_cfg_data[bld_pkg::RATE_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/bld_in_stage.sv
// ----------------------------------------------------------------------------
// bld_in_stage
// Input register; forms the ramp products rate * elapsed for the held item.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_in_stage (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [2:0]              i_op,
    input  wire logic [bld_pkg::STAMP_W-1:0] i_now_ms,
    input  wire bld_pkg::t_cfg           i_cfg,
    input  wire bld_pkg::t_stamps        i_stamps,
    input  wire logic                    i_take,
    output logic                         o_valid,
    output bld_pkg::t_item               o_item
);

    logic                          r_valid;
    bld_pkg::t_item                r_item;
    logic                          accept;
    logic [bld_pkg::STAMP_W-1:0]   stamp_sel;
    logic [bld_pkg::STAMP_W-1:0]   el_stamp;
    logic [bld_pkg::STAMP_W-1:0]   el_prev;
    logic [bld_pkg::ELAPSED_W-1:0] sat_stamp;
    logic [bld_pkg::ELAPSED_W-1:0] sat_prev;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Elapsed beyond 21 bits saturates to all ones, which saturates the step whenever the rate is nonzero.
    always_comb begin
        stamp_sel = (bld_pkg::t_op'(i_op) == bld_pkg::OP_UP_POLL) ? i_stamps.up_stamp
                                                                  : i_stamps.down_stamp;
        el_stamp  = i_now_ms - stamp_sel;
        el_prev   = i_now_ms - r_item.now_ms;
        sat_stamp = (|el_stamp[bld_pkg::STAMP_W-1:bld_pkg::ELAPSED_W]) ? '1
                  : el_stamp[bld_pkg::ELAPSED_W-1:0];
        sat_prev  = (|el_prev[bld_pkg::STAMP_W-1:bld_pkg::ELAPSED_W]) ? '1
                  : el_prev[bld_pkg::ELAPSED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op         <= i_op;
            r_item.now_ms     <= i_now_ms;
            r_item.prod_stamp <= bld_pkg::PROD_W'(i_cfg.ramp_rate)
                               * bld_pkg::PROD_W'(sat_stamp);
            r_item.prod_prev  <= bld_pkg::PROD_W'(i_cfg.ramp_rate)
                               * bld_pkg::PROD_W'(sat_prev);
            r_item.prev_back  <= r_valid;
        end
    end

endmodule

`default_nettype wire

>>> src/bld_core.sv
// ----------------------------------------------------------------------------
// bld_core
// Lamp state update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bld_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire bld_pkg::t_item i_item,
    input  wire bld_pkg::t_cfg  i_cfg,
    output logic              o_take,
    output bld_pkg::t_stamps  o_stamps,
    output logic              o_valid,
    input  wire logic         i_ready,
    output bld_pkg::t_result  o_result
);

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_WAIT  = 2'd1,
        PH_RAMP  = 2'd2
    } t_phase;

    logic                          r_lamp_on,     n_lamp_on;
    logic                          r_toggle_held, n_toggle_held;
    t_phase                        r_up_phase,    n_up_phase;
    t_phase                        r_down_phase,  n_down_phase;
    logic [bld_pkg::STAMP_W-1:0]   r_up_stamp,    n_up_stamp;
    logic [bld_pkg::STAMP_W-1:0]   r_down_stamp,  n_down_stamp;
    logic [bld_pkg::LEVEL_W-1:0]   r_level,       n_level;
    logic                          r_up_fresh,    n_up_fresh;
    logic                          r_down_fresh,  n_down_fresh;
    logic                          r_out_valid;
    bld_pkg::t_result              r_result,      n_result;

    bld_pkg::t_op                  op;
    logic                          is_up;
    t_phase                        phase;
    logic [bld_pkg::STAMP_W-1:0]   stamp;
    logic [bld_pkg::STAMP_W-1:0]   elapsed;
    logic [bld_pkg::PROD_W-1:0]    prod;
    logic [bld_pkg::QPROD_W-1:0]   qprod;
    logic [bld_pkg::STEP_W-1:0]    step;
    logic                          step_zero;
    logic [bld_pkg::SUM_W-1:0]     amount;
    logic signed [bld_pkg::SUM_W-1:0] sum;
    logic [bld_pkg::LEVEL_W-1:0]   stepped;
    logic [bld_pkg::LEVEL_W-1:0]   on_level;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign o_stamps = '{up_stamp: r_up_stamp, down_stamp: r_down_stamp};

    // Ramp step: pick the product made against the right stamp, then divide by 1000.
    always_comb begin
        op      = bld_pkg::t_op'(i_item.op);
        is_up   = (op == bld_pkg::OP_UP_POLL);
        phase   = is_up ? r_up_phase : r_down_phase;
        stamp   = is_up ? r_up_stamp : r_down_stamp;
        elapsed = i_item.now_ms - stamp;
        prod    = (i_item.prev_back && (is_up ? r_up_fresh : r_down_fresh))
                ? i_item.prod_prev : i_item.prod_stamp;
        qprod   = bld_pkg::QPROD_W'(prod[bld_pkg::ELAPSED_W-1:0])
                * bld_pkg::QPROD_W'(bld_pkg::RECIP_1000);
        if (prod >= bld_pkg::STEP_SAT_PROD) begin
            step = '1;
        end else begin
            step = qprod[bld_pkg::RECIP_SH +: bld_pkg::STEP_W];
        end
        step_zero = (prod < bld_pkg::STEP_MIN_PROD);
        amount    = (phase == PH_FIRST) ? bld_pkg::SUM_W'(i_cfg.first_step)
                                        : bld_pkg::SUM_W'(step);
        sum       = is_up ? ($signed(bld_pkg::SUM_W'(r_level)) + $signed(amount))
                          : ($signed(bld_pkg::SUM_W'(r_level)) - $signed(amount));
        stepped   = bld_pkg::clamp_level(sum, i_cfg.high_limit, i_cfg.low_limit);
        on_level  = bld_pkg::clamp_level($signed(bld_pkg::SUM_W'(r_level)),
                                         i_cfg.high_limit, i_cfg.low_limit);
    end

    always_comb begin
        n_lamp_on     = r_lamp_on;
        n_toggle_held = r_toggle_held;
        n_up_phase    = r_up_phase;
        n_down_phase  = r_down_phase;
        n_up_stamp    = r_up_stamp;
        n_down_stamp  = r_down_stamp;
        n_level       = r_level;
        n_up_fresh    = 1'b0;
        n_down_fresh  = 1'b0;
        n_result      = '0;

        unique case (op)
            bld_pkg::OP_TOGGLE_PRESS, bld_pkg::OP_UP_POLL, bld_pkg::OP_DOWN_POLL: begin
                if (op == bld_pkg::OP_TOGGLE_PRESS || !r_lamp_on) begin
                    // press: ignored while the toggle is still held
                    if (!r_toggle_held) begin
                        n_toggle_held       = 1'b1;
                        n_lamp_on           = !r_lamp_on;
                        n_result.duty_write = 1'b1;
                        n_result.duty_value = r_lamp_on ? '0 : on_level;
                    end
                end else begin
                    unique case (phase)
                        PH_FIRST: begin
                            n_level             = stepped;
                            n_result.duty_write = 1'b1;
                            n_result.duty_value = stepped;
                            if (is_up) begin
                                n_up_stamp = i_item.now_ms;
                                n_up_fresh = 1'b1;
                                n_up_phase = PH_WAIT;
                            end else begin
                                n_down_stamp = i_item.now_ms;
                                n_down_fresh = 1'b1;
                                n_down_phase = PH_WAIT;
                            end
                        end
                        PH_WAIT: begin
                            if (elapsed > bld_pkg::STAMP_W'(i_cfg.hold_wait_ms)) begin
                                if (is_up) begin
                                    n_up_stamp = i_item.now_ms;
                                    n_up_fresh = 1'b1;
                                    n_up_phase = PH_RAMP;
                                end else begin
                                    n_down_stamp = i_item.now_ms;
                                    n_down_fresh = 1'b1;
                                    n_down_phase = PH_RAMP;
                                end
                            end
                        end
                        PH_RAMP: begin
                            if (!step_zero) begin
                                n_level             = stepped;
                                n_result.duty_write = 1'b1;
                                n_result.duty_value = stepped;
                                if (is_up) begin
                                    n_up_stamp = i_item.now_ms;
                                    n_up_fresh = 1'b1;
                                end else begin
                                    n_down_stamp = i_item.now_ms;
                                    n_down_fresh = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // unused phase code: ignore the poll
                        end
                    endcase
                end
            end
            bld_pkg::OP_TOGGLE_REL: n_toggle_held = 1'b0;
            bld_pkg::OP_UP_REL:     n_up_phase    = PH_FIRST;
            bld_pkg::OP_DOWN_REL:   n_down_phase  = PH_FIRST;
            default: begin
                // unused opcodes: no write, no change
            end
        endcase

        n_result.lamp_is_on = n_lamp_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_on     <= 1'b0;
            r_toggle_held <= 1'b0;
            r_up_phase    <= PH_FIRST;
            r_down_phase  <= PH_FIRST;
            r_up_stamp    <= '0;
            r_down_stamp  <= '0;
            r_level       <= '0;
            r_up_fresh    <= 1'b0;
            r_down_fresh  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_take) begin
                r_lamp_on     <= n_lamp_on;
                r_toggle_held <= n_toggle_held;
                r_up_phase    <= n_up_phase;
                r_down_phase  <= n_down_phase;
                r_up_stamp    <= n_up_stamp;
                r_down_stamp  <= n_down_stamp;
                r_level       <= n_level;
                r_up_fresh    <= n_up_fresh;
                r_down_fresh  <= n_down_fresh;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

>>> src/button_lamp_dimmer.sv
// ----------------------------------------------------------------------------
// button_lamp_dimmer
// PWM lamp dimmer driven by toggle, up and down button events.
// ----------------------------------------------------------------------------
// Each input transaction is one button event (opcode on s_axis_tuser) with a
// millisecond timestamp (s_axis_tdata); each one yields exactly one output
// transaction carrying the duty written (if any), a write flag and the lamp
// state after the event. The block takes one event per clock while the result
// stream is not stalled. An accepted event is registered together with the
// ramp product ramp_rate * elapsed, formed on the way in; the state update then
// divides that product by 1000 through a reciprocal multiply, clamps the new
// level and loads the output register, from which the result is offered. With
// the result stream stalled the block holds two events, one in the output
// register and one in the input register, and then drops s_axis_tready until
// the waiting result leaves. Write configuration only while no event is in
// flight; writes to indexes past the ramp rate are dropped. Duty bits at and
// above DUTY_BITS are forced to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module button_lamp_dimmer #(
    parameter int DUTY_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // event stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] now_ms
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] opcode
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [9:0] duty_value, [10] lamp_is_on, rest zero
    output logic             m_axis_tuser,   // [0] duty_write
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [bld_pkg::LEVEL_W-1:0] DutyMask =
        (DUTY_BITS >= bld_pkg::LEVEL_W) ? {bld_pkg::LEVEL_W{1'b1}}
                                        : bld_pkg::LEVEL_W'((1 << DUTY_BITS) - 1);

    bld_pkg::t_cfg    cfg;
    bld_pkg::t_stamps stamps;
    bld_pkg::t_item   item;
    bld_pkg::t_result result;
    logic             item_valid;
    logic             core_take;
    logic             off_write;
    logic             in_accept;

    bld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register: holds one event plus both candidate ramp products.
    bld_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser),
        .i_now_ms (s_axis_tdata),
        .i_cfg    (cfg),
        .i_stamps (stamps),
        .i_take   (core_take),
        .o_valid  (item_valid),
        .o_item   (item)
    );

    // State update and result register.
    bld_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_take   (core_take),
        .o_stamps (stamps),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack the result; mask duty to the PWM width.
    assign m_axis_tdata = {5'b0, result.lamp_is_on, result.duty_value & DutyMask};
    assign m_axis_tuser = result.duty_write;

    assign off_write = m_axis_tvalid && result.duty_write && !result.lamp_is_on;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Switching off always writes a zero duty.
    `ASSERT_IMPLY(a_off_write_zero, off_write, result.duty_value == '0, "off write not zero")
    // A new event enters only when the held one moves on or none is held.
    `ASSERT_IMPLY(a_in_reg_free, in_accept, !item_valid || core_take, "input reg overwritten")
    // A processed event always leaves a result in the output register.
    `ASSERT_CLK(a_take_to_result, core_take |=> m_axis_tvalid, "processed event left no result")

endmodule

`default_nettype wire
